@@ src/itb_pkg.sv @@
// Shared types, constants and helpers for the isometric triangle blitter.
// No dependencies; imported by itb_raster and iso_triangle_blitter.
package itb_pkg;

  localparam int SCREEN_W = 320;
  localparam int SCREEN_H = 240;

  localparam int COL_W  = $clog2(SCREEN_W);
  localparam int ROW_W  = $clog2(SCREEN_H);
  localparam int PROD_W = COL_W + ROW_W;
  localparam int ADDR_W = 17;
  localparam int COLOR_W = 16;

  localparam int TRI_TEXELS = 128;
  localparam int HALF_ROWS  = 8;
  localparam int MAX_WIDTH  = 16;
  localparam int WIDTH_STEP = 2;

  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 40;

  // request kinds carried in tuser
  localparam logic [1:0] REQ_START   = 2'd0;
  localparam logic [1:0] REQ_TEXEL   = 2'd1;
  localparam logic [1:0] REQ_PALETTE = 2'd2;

  // fill modes
  localparam logic [1:0] MODE_TEXTURE = 2'd0;
  localparam logic [1:0] MODE_SKY     = 2'd1;
  localparam logic [1:0] MODE_KEYED   = 2'd2;

  // input tdata field offsets
  localparam int OX_LSB     = 0;
  localparam int OY_LSB     = 12;
  localparam int FACING_BIT = 24;
  localparam int MODE_LSB   = 25;
  localparam int FLAGS_LSB  = 27;
  localparam int TEXEL_LSB  = 35;
  localparam int SHADOW_LSB = 43;
  localparam int WATER_LSB  = 51;
  localparam int PIDX_LSB   = 59;
  localparam int PCOLOR_LSB = 67;

  // one texel's result leaving the raster stage
  typedef struct packed {
    logic             result;
    logic             write;
    logic [7:0]       idx;
    logic [COL_W-1:0] dx;
    logic [ROW_W-1:0] dy;
    logic             last;
  } itb_px_t;

  function automatic logic [4:0] row_width(logic [3:0] r);
    if (int'(r) < HALF_ROWS) begin
      return 5'(WIDTH_STEP * (int'(r) + 1));
    end
    return 5'(MAX_WIDTH - WIDTH_STEP * (int'(r) - (HALF_ROWS - 1)));
  endfunction

endpackage

@@ src/itb_raster.sv @@
// Triangle traversal: latches the start item, walks rows and columns, forms the
// colour index and clips each texel. Depends on itb_pkg.
module itb_raster
  import itb_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  logic [1:0]            req_i,
  input  logic [IN_TDATA_W-1:0] data_i,
  input  logic [7:0]            sky_index_i,
  output itb_px_t               px_o
);

  logic [7:0]  count_q, count_d;
  logic [3:0]  row_q, row_d;
  logic [4:0]  col_q, col_d;
  logic [11:0] ax_q, ax_d;
  logic [11:0] ay_q, ay_d;
  logic        facing_q, facing_d;
  logic [1:0]  mode_q, mode_d;
  logic [7:0]  flags_q, flags_d;

  logic [7:0]  texel, shadow, water;
  logic [4:0]  width;
  logic        active;
  logic [13:0] dx;
  logic [12:0] dy;
  logic        on_screen;
  logic        wr;
  logic [7:0]  idx;

  assign texel  = data_i[TEXEL_LSB +: 8];
  assign shadow = data_i[SHADOW_LSB +: 8];
  assign water  = data_i[WATER_LSB +: 8];

  assign width  = row_width(row_q);
  assign active = (count_q < 8'(TRI_TEXELS));

  always_comb begin
    if (facing_q) begin
      dx = {{2{ax_q[11]}}, ax_q} + 14'(col_q);
    end else begin
      dx = {{2{ax_q[11]}}, ax_q} - 14'(width) + 14'(col_q);
    end
    dy = {ay_q[11], ay_q} + 13'(row_q);
  end

  // sign bit clear means non-negative, then compare as unsigned
  assign on_screen = !dx[13] && (dx < 14'(SCREEN_W)) && !dy[12] && (dy < 13'(SCREEN_H));

  always_comb begin
    wr  = 1'b1;
    idx = 8'd0;
    unique case (mode_q)
      MODE_TEXTURE: idx = texel | shadow | water;
      MODE_SKY:     idx = sky_index_i | water;
      MODE_KEYED: begin
        idx = texel | flags_q;
        if (texel == 8'd0) wr = 1'b0;
      end
      default: wr = 1'b0;
    endcase
    if (!on_screen) wr = 1'b0;
  end

  always_comb begin
    px_o.result = (req_i == REQ_TEXEL) && active;
    px_o.write  = wr;
    px_o.idx    = idx;
    px_o.dx     = dx[COL_W-1:0];
    px_o.dy     = dy[ROW_W-1:0];
    px_o.last   = (count_q == 8'(TRI_TEXELS - 1));
  end

  always_comb begin
    count_d  = count_q;
    row_d    = row_q;
    col_d    = col_q;
    ax_d     = ax_q;
    ay_d     = ay_q;
    facing_d = facing_q;
    mode_d   = mode_q;
    flags_d  = flags_q;
    if (fire_i) begin
      if (req_i == REQ_START) begin
        ax_d     = data_i[OX_LSB +: 12];
        ay_d     = data_i[OY_LSB +: 12];
        facing_d = data_i[FACING_BIT];
        mode_d   = data_i[MODE_LSB +: 2];
        flags_d  = data_i[FLAGS_LSB +: 8];
        count_d  = 8'd0;
        row_d    = 4'd0;
        col_d    = 5'd0;
      end else if (px_o.result) begin
        count_d = count_q + 8'd1;
        if (({1'b0, col_q} + 6'd1) >= {1'b0, width}) begin
          col_d = 5'd0;
          row_d = row_q + 4'd1;
        end else begin
          col_d = col_q + 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= 8'(TRI_TEXELS);
      row_q    <= 4'd0;
      col_q    <= 5'd0;
      ax_q     <= 12'd0;
      ay_q     <= 12'd0;
      facing_q <= 1'b0;
      mode_q   <= 2'd0;
      flags_q  <= 8'd0;
    end else begin
      count_q  <= count_d;
      row_q    <= row_d;
      col_q    <= col_d;
      ax_q     <= ax_d;
      ay_q     <= ay_d;
      facing_q <= facing_d;
      mode_q   <= mode_d;
      flags_q  <= flags_d;
    end
  end

endmodule

@@ src/iso_triangle_blitter.sv @@
// Isometric triangle blitter top level: palette memory and result pipeline.
// Depends on itb_pkg and itb_raster.
//
// Usage: a stream on s_axis carries requests, the kind in tuser: a start item
// latches origin, facing, fill mode and flags; 128 texel items follow in row
// order; palette write items load the 256-entry colour palette, which must be
// written before the entries are used. The user must write sky_index on cfg only
// while idle; the block itself does not enforce it. Each accepted texel of an
// active triangle yields one transfer on m_axis: tuser is the written flag, tdata
// the framebuffer address and colour (both zero when the pixel is clipped or
// transparent), tlast marks the 128th texel. Start, palette and surplus texel
// items yield nothing. Throughput: one item per cycle while m_axis accepts. A
// result passes the raster and palette read register, then the address register.
// When the receiver stalls, both stages fill and s_axis_tready drops; no
// result is lost. Reset empties the pipeline and leaves no triangle active;
// the palette is not cleared.
module iso_triangle_blitter
  import itb_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [7:0]             cfg_data_i,     // sky_index
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // x origin, y origin, facing, fill_mode, flag_bits, texel, shadow_bits,
  // water_bits, palette_index, palette_color, zero pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic [1:0]             s_axis_tuser,   // req_type
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // pixel_address, pixel_color, zero pad
  output logic                   m_axis_tuser,   // pixel_written
  output logic                   m_axis_tlast    // last_texel
);

  logic [7:0] sky_q;

  itb_px_t px;
  logic    s_fire;
  logic    s1_move;

  logic               s1_valid_q;
  logic               s1_write_q;
  logic [COL_W-1:0]   s1_dx_q;
  logic [ROW_W-1:0]   s1_dy_q;
  logic               s1_last_q;
  logic [COLOR_W-1:0] rd_q;

  logic               out_valid_q;
  logic               out_write_q;
  logic [ADDR_W-1:0]  out_addr_q;
  logic [COLOR_W-1:0] out_color_q;
  logic               out_last_q;
  logic [ADDR_W-1:0]  addr_d;

  logic [COLOR_W-1:0] palette_mem [256];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sky_q <= 8'd0;
    end else if (cfg_valid_i) begin
      sky_q <= cfg_data_i;
    end
  end

  assign s1_move       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || s1_move;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  itb_raster u_raster (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (s_fire),
    .req_i       (s_axis_tuser),
    .data_i      (s_axis_tdata),
    .sky_index_i (sky_q),
    .px_o        (px)
  );

  // palette: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (s_fire && (s_axis_tuser == REQ_PALETTE)) begin
      palette_mem[s_axis_tdata[PIDX_LSB +: 8]] <= s_axis_tdata[PCOLOR_LSB +: COLOR_W];
    end
    if (s_fire && px.result) begin
      rd_q <= palette_mem[px.idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_fire) begin
      s1_valid_q <= px.result;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire && px.result) begin
      s1_write_q <= px.write;
      s1_dx_q    <= px.dx;
      s1_dy_q    <= px.dy;
      s1_last_q  <= px.last;
    end
  end

  assign addr_d = ADDR_W'(PROD_W'(SCREEN_W) * PROD_W'(s1_dy_q) + PROD_W'(s1_dx_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move && s1_valid_q) begin
      out_write_q <= s1_write_q;
      out_addr_q  <= s1_write_q ? addr_d : '0;
      out_color_q <= s1_write_q ? rd_q : '0;
      out_last_q  <= s1_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W - ADDR_W - COLOR_W){1'b0}}, out_color_q, out_addr_q};
  assign m_axis_tuser  = out_write_q;
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
  a_stall_holds_s1 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_move |=> s1_valid_q)
    else $error("stage 1 result dropped during output stall");

  a_ready_only_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> s1_valid_q && out_valid_q)
    else $error("input stalled while pipeline has room");

  a_unwritten_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("non-written pixel carries nonzero data");

  a_s1_from_texel : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(s1_valid_q) |-> $past(s_fire))
    else $error("stage 1 filled without an input transfer");
`endif

endmodule
